// File: src/mcce_pkg.sv
`default_nettype none

package mcce_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned DIM_BITS_DEF    = 8;

  // Dimension table size, one entry per letter.
  localparam logic [4:0] NUM_LETTERS = 5'd26;

  // Input kinds.
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EXPR = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Expression symbols.
  localparam logic [7:0] SYM_OPEN  = 8'h28;
  localparam logic [7:0] SYM_CLOSE = 8'h29;
  localparam logic [7:0] SYM_A     = 8'h41;
  localparam logic [7:0] SYM_Z     = 8'h5A;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISMATCH  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] letter;
    logic [7:0] rows;
    logic [7:0] cols;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_mults;
    logic [1:0]  status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       tbl_we;
    logic       push;
    logic       pop_rd;
    logic       mul_lo;
    logic       mul_hi;
    logic       reduce;
    logic       err_we;
    logic [1:0] err_code;
    logic       emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;
    logic full;
    logic err_set;
    logic mismatch;
  } sts_t;

endpackage

`default_nettype wire

// File: src/mcce_ctrl.sv
`default_nettype none

module mcce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mcce_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mcce_pkg::cmd_t    cmd_o,
  input  mcce_pkg::sts_t    sts_i
);
  import mcce_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       is_letter;

  assign is_letter   = (in_data_i.symbol >= SYM_A) && (in_data_i.symbol <= SYM_Z);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.kind)
            KIND_LOAD: begin
              cmd_o.tbl_we = (in_data_i.letter < NUM_LETTERS);
            end
            KIND_EXPR: begin
              if (!sts_i.err_set) begin
                if (in_data_i.symbol == SYM_CLOSE) begin
                  if (sts_i.below_two) begin
                    cmd_o.err_we   = 1'b1;
                    cmd_o.err_code = ST_MALFORMED;
                  end else begin
                    cmd_o.pop_rd = 1'b1;
                    state_d      = S_CMP;
                  end
                end else if (is_letter) begin
                  if (sts_i.full) begin
                    cmd_o.err_we   = 1'b1;
                    cmd_o.err_code = ST_MALFORMED;
                  end else begin
                    cmd_o.push = 1'b1;
                  end
                end
              end
            end
            KIND_END: begin
              state_d = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_CMP: begin
        if (sts_i.mismatch) begin
          cmd_o.err_we   = 1'b1;
          cmd_o.err_code = ST_MISMATCH;
          state_d        = S_IDLE;
        end else begin
          cmd_o.mul_lo = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.reduce = 1'b1;
        state_d      = S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: src/mcce_dp.sv
`default_nettype none

module mcce_dp #(
  parameter int unsigned STACK_DEPTH = mcce_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DIM_BITS    = mcce_pkg::DIM_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcce_pkg::in_item_t  in_data_i,
  input  mcce_pkg::cmd_t      cmd_i,
  output mcce_pkg::sts_t      sts_o,
  output mcce_pkg::out_item_t out_data_o
);
  import mcce_pkg::*;

  localparam int unsigned DW = 2 * DIM_BITS;
  localparam int unsigned PW = 3 * DIM_BITS;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SW = ((PW > 32) ? PW : 32) + 1;

  // Each entry holds rows in the upper half and cols in the lower half.
  logic [DW-1:0] tbl_q [26];
  logic [DW-1:0] stk_mem [STACK_DEPTH];
  logic [DW-1:0] tos_q;
  logic [DW-1:0] left_q;
  logic [LW-1:0] level_q;
  logic [31:0]   total_q;
  logic [1:0]    err_q;
  logic [DW-1:0] p1_q;
  logic [PW-1:0] p2_q;
  out_item_t     out_q;

  logic [LW-1:0] level_m1, level_m2;
  logic [7:0]    sym_off;
  logic [4:0]    push_idx;
  logic [SW-1:0] sum;
  logic [31:0]   sum_sat;

  assign level_m1 = level_q - LW'(1);
  assign level_m2 = level_q - LW'(2);
  assign sym_off  = in_data_i.symbol - SYM_A;
  assign push_idx = sym_off[4:0];
  assign sum      = SW'(total_q) + SW'(p2_q);
  assign sum_sat  = (sum[SW-1:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];

  assign sts_o.below_two = (level_q < LW'(2));
  assign sts_o.full      = (level_q == LW'(STACK_DEPTH));
  assign sts_o.err_set   = (err_q != ST_OK);
  assign sts_o.mismatch  = (left_q[DIM_BITS-1:0] != tos_q[DW-1:DIM_BITS]);
  assign out_data_o      = out_q;

  // Dimension table, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 26; i++) begin
        tbl_q[i] <= '0;
      end
    end else if (cmd_i.tbl_we) begin
      tbl_q[in_data_i.letter] <= {DIM_BITS'(in_data_i.rows), DIM_BITS'(in_data_i.cols)};
    end
  end

  // Entries below the top of stack live in memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (level_q != '0)) begin
      stk_mem[level_m1[AW-1:0]] <= tos_q;
    end
    if (cmd_i.pop_rd) begin
      left_q <= stk_mem[level_m2[AW-1:0]];
    end
  end

  // Cost pipeline and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      p1_q <= DW'(left_q[DW-1:DIM_BITS]) * DW'(left_q[DIM_BITS-1:0]);
    end
    if (cmd_i.mul_hi) begin
      p2_q <= PW'(p1_q) * PW'(tos_q[DIM_BITS-1:0]);
    end
    if (cmd_i.push) begin
      tos_q <= tbl_q[push_idx];
    end else if (cmd_i.reduce) begin
      tos_q <= {left_q[DW-1:DIM_BITS], tos_q[DIM_BITS-1:0]};
    end
    if (cmd_i.emit) begin
      out_q.total_mults <= total_q;
      out_q.status      <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      total_q <= '0;
      err_q   <= ST_OK;
    end else if (cmd_i.emit) begin
      level_q <= '0;
      total_q <= '0;
      err_q   <= ST_OK;
    end else begin
      if (cmd_i.push) begin
        level_q <= level_q + LW'(1);
      end else if (cmd_i.reduce) begin
        level_q <= level_m1;
        total_q <= sum_sat;
      end
      if (cmd_i.err_we) begin
        err_q <= cmd_i.err_code;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/matrix_chain_cost_evaluator.sv
// A load, a letter, an ignored byte or a close paren with fewer than two operands is handled
// in the idle state; a reducing close paren goes on through stack read, compare and first
// product, second product and accumulate, or stops after the compare when the inner
// dimensions disagree. An end beat moves to the emit state, which holds off input and waits
// for an earlier result beat, then loads the result and raises valid. Idle: one beat per cycle.
// Reset (asynchronous, active low) clears the dimension table, stack level, total and status.
`default_nettype none

module matrix_chain_cost_evaluator #(
  parameter int unsigned STACK_DEPTH = mcce_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DIM_BITS    = mcce_pkg::DIM_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mcce_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcce_pkg::out_item_t out_data_o
);
  import mcce_pkg::*;

  // The controller decodes each accepted beat and sequences the multi-cycle
  // reduction of a close paren; the datapath holds the table, the stack with
  // its top entry in a register, the two-step cost multiply and the total.
  cmd_t cmd;
  sts_t sts;

  mcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The result register lives in the datapath, so a finished result can wait
  // for the consumer while new beats keep flowing in.
  mcce_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .DIM_BITS   (DIM_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

// File: src/mcce_checker.sv
`default_nettype none

module mcce_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input mcce_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mcce_pkg::out_item_t out_data_o
);
  import mcce_pkg::*;

  logic end_beat;
  assign end_beat = in_valid_i && in_ready_o && (in_data_i.kind == KIND_END);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK) || (out_data_o.status == ST_MISMATCH) ||
                    (out_data_o.status == ST_MALFORMED))
    else $error("undefined status code");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_beat |=> !in_ready_o)
    else $error("input taken while an end beat is being emitted");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_beat && (!out_valid_o || out_ready_i) |=> ##1 out_valid_o)
    else $error("end beat produced no result");

endmodule

bind matrix_chain_cost_evaluator mcce_checker u_mcce_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
